[rtl/gsef_pkg.sv]
// Shared types and constants of the grayscale Sobel edge filter.
package gsef_pkg;

  localparam int unsigned WidthRegW  = 12;
  localparam int unsigned HeightRegW = 16;
  localparam int unsigned CfgDataW   = 16;

  typedef enum logic {
    CfgWidth  = 1'b0,
    CfgHeight = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_t;

  typedef struct packed {
    logic [10:0] out_column;
    logic [15:0] out_row;
    logic [7:0]  edge_value;
    logic        frame_done;
    logic        last_of_run;
  } res_t;

  // One classified pixel job handed from front to back.
  typedef struct packed {
    logic [7:0]  gray;
    logic [7:0]  top;
    logic [7:0]  mid;
    logic [10:0] col;
    logic [15:0] row;
    logic        emit_win;   // result for (r-1, c-1)
    logic        win_inner;  // that result is interior
    logic        emit_edge;  // result for (r-1, W-1)
    logic        emit_last;  // result for (r, c)
    logic        frame_end;
  } job_t;

  // floor(v/100) for v <= 25500, via reciprocal and one correction.
  function automatic logic [7:0] div100(input logic [14:0] v);
    logic [31:0] p;
    logic [8:0]  q;
    logic [15:0] rem;
    begin
      p = 32'(v) * 32'd41944;
      q = p[30:22];
      rem = 16'(v) - 16'(q) * 16'd100;
      if (rem >= 16'd100) q = q + 9'd1;
      div100 = q[7:0];
    end
  endfunction

endpackage

[rtl/gsef_front.sv]
// Front end: gray conversion, line stores, position tracking and result classification.
module gsef_front #(
  parameter int unsigned MaxWidth = 2048
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         restart_i,
  input  logic [gsef_pkg::WidthRegW-1:0]  width_i,
  input  logic [gsef_pkg::HeightRegW-1:0] height_i,
  input  logic                         push_i,
  input  gsef_pkg::pix_t               pix_i,
  output logic                         full_o,
  output logic                         job_valid_o,
  output gsef_pkg::job_t               job_o,
  input  logic                         job_ready_i
);
  import gsef_pkg::*;

  localparam int unsigned AddrW = $clog2(MaxWidth);

  logic [7:0] older_mem [MaxWidth];
  logic [7:0] newer_mem [MaxWidth];

  logic [13:0] eff_w;
  logic [15:0] eff_h;
  logic [13:0] col_q, col_d;
  logic [15:0] row_q, row_d;

  // Stage 1 registers (pixel read issued).
  logic        s1_valid_q;
  logic [7:0]  s1_gray_q;
  logic [14:0] s1_sum;
  logic [13:0] s1_col_q;
  logic [15:0] s1_row_q;
  logic        s1_cend_q, s1_rlast_q, s1_inner_q;
  logic [7:0]  top_q, mid_q;
  logic        wb_q;
  logic        accept, adv;

  always_comb begin
    eff_w = (width_i == '0) ? 14'd1 :
            ((14'(width_i) > 14'(MaxWidth)) ? 14'(MaxWidth) : 14'(width_i));
    eff_h = (height_i == '0) ? 16'd1 : height_i;
  end

  assign adv    = !job_valid_o || job_ready_i;
  assign full_o = s1_valid_q && !adv;
  assign accept = push_i && !full_o;

  assign s1_sum = 15'(15'd30 * 15'(pix_i.red) + 15'd59 * 15'(pix_i.green)
                  + 15'd11 * 15'(pix_i.blue));

  always_comb begin
    col_d = col_q + 14'd1;
    row_d = row_q;
    if (col_d >= eff_w) begin
      col_d = '0;
      row_d = (row_q + 16'd1 >= eff_h) ? 16'd0 : row_q + 16'd1;
    end
  end

  logic [AddrW-1:0] rd_addr;
  assign rd_addr = col_q[AddrW-1:0];

  always_ff @(posedge clk_i) begin
    if (wb_q) older_mem[s1_col_q[AddrW-1:0]] <= mid_q;
    if (accept) begin
      top_q <= older_mem[rd_addr];
      mid_q <= newer_mem[rd_addr];
      newer_mem[rd_addr] <= div100(s1_sum);
      s1_gray_q <= div100(s1_sum);
      s1_col_q  <= col_q;
      s1_row_q  <= row_q;
      s1_cend_q <= (col_q + 14'd1 == eff_w);
      s1_rlast_q <= (row_q + 16'd1 == eff_h);
      s1_inner_q <= (row_q >= 16'd2) && (row_q < eff_h) &&
                    (col_q >= 14'd2) && (col_q < eff_w);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      s1_valid_q <= 1'b0;
      job_valid_o <= 1'b0;
      wb_q <= 1'b0;
    end else begin
      wb_q <= accept;
      if (restart_i) begin
        col_q <= '0;
        row_q <= '0;
      end else if (accept) begin
        col_q <= col_d;
        row_q <= row_d;
      end
      if (adv) begin
        job_valid_o <= s1_valid_q;
      end
      if (adv || !s1_valid_q) begin
        s1_valid_q  <= accept;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s1_valid_q) begin
      job_o.gray      <= s1_gray_q;
      job_o.top       <= top_q;
      job_o.mid       <= mid_q;
      job_o.col       <= s1_col_q[10:0];
      job_o.row       <= s1_row_q;
      job_o.emit_win  <= (s1_row_q != 0) && (s1_col_q != 0);
      job_o.win_inner <= s1_inner_q;
      job_o.emit_edge <= (s1_row_q != 0) && s1_cend_q;
      job_o.emit_last <= s1_rlast_q;
      job_o.frame_end <= s1_rlast_q && s1_cend_q;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) full_o |-> s1_valid_q)
    else $error("full without pending pixel");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !restart_i) |=> (col_q < eff_w || $past(restart_i)))
    else $error("column ran past width");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (job_valid_o && !job_ready_i) |=> job_valid_o)
    else $error("job dropped while stalled");

endmodule

[rtl/gsef_back.sv]
// Back end: window, Sobel magnitude and result register.
module gsef_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            restart_i,
  input  logic            job_valid_i,
  input  gsef_pkg::job_t  job_i,
  output logic            job_ready_o,
  output logic            empty,
  input  logic            pop,
  output gsef_pkg::res_t  res_o
);
  import gsef_pkg::*;

  typedef enum logic [2:0] {
    StIdle, StSq, StSqrt, StEmit
  } state_e;

  state_e      state_q;
  job_t        job_q;
  logic [7:0]  win_q [6];
  logic [10:0] ax_q, ay_q;
  logic [21:0] sq_x_q, sq_y_q;
  logic [16:0] rem_q;
  logic [8:0]  res_q;
  logic [3:0]  it_q;
  logic [7:0]  mag_q;
  logic [1:0]  slot_q;
  res_t        out_q;
  logic        out_valid_q;

  logic signed [11:0] gx, gy;
  always_comb begin
    gx = 12'(job_i.top) + 12'(job_i.mid) * 12'sd2 + 12'(job_i.gray)
       - 12'(win_q[0]) - 12'(win_q[1]) * 12'sd2 - 12'(win_q[2]);
    gy = 12'(win_q[0]) + 12'(win_q[3]) * 12'sd2 + 12'(job_i.top)
       - 12'(win_q[2]) - 12'(win_q[5]) * 12'sd2 - 12'(job_i.gray);
  end

  logic [22:0] ssum;
  assign ssum = 23'(sq_x_q) + 23'(sq_y_q);

  logic [15:0] sval;

  assign job_ready_o = (state_q == StIdle);
  assign empty = !out_valid_q;
  assign res_o = out_q;

  logic       want [3];
  logic       more_after [3];
  always_comb begin
    want[0] = job_q.emit_win;
    want[1] = job_q.emit_edge;
    want[2] = job_q.emit_last;
    more_after[0] = job_q.emit_edge || job_q.emit_last;
    more_after[1] = job_q.emit_last;
    more_after[2] = 1'b0;
  end

  logic take, emit_now;
  assign take     = (state_q == StIdle) && job_valid_i;
  assign emit_now = (state_q == StEmit) && want[slot_q] && (!out_valid_q || pop);

  assign sval = ssum[15:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      out_valid_q <= 1'b0;
      slot_q <= '0;
      for (int i = 0; i < 6; i++) win_q[i] <= '0;
    end else begin
      if (pop && out_valid_q && !emit_now) out_valid_q <= 1'b0;
      if (restart_i && !take) for (int i = 0; i < 6; i++) win_q[i] <= '0;
      case (state_q)
        StIdle: begin
          if (job_valid_i) begin
            job_q <= job_i;
            ax_q  <= gx[11] ? 11'(-gx) : 11'(gx);
            ay_q  <= gy[11] ? 11'(-gy) : 11'(gy);
            mag_q <= win_q[4];
            win_q[0] <= win_q[3];
            win_q[1] <= win_q[4];
            win_q[2] <= win_q[5];
            win_q[3] <= job_i.top;
            win_q[4] <= job_i.mid;
            win_q[5] <= job_i.gray;
            slot_q <= '0;
            state_q <= (job_i.emit_win && job_i.win_inner) ? StSq : StEmit;
          end
        end
        StSq: begin
          sq_x_q <= 22'(ax_q) * 22'(ax_q);
          sq_y_q <= 22'(ay_q) * 22'(ay_q);
          it_q   <= 4'd0;
          rem_q  <= '0;
          res_q  <= '0;
          state_q <= StSqrt;
        end
        StSqrt: begin
          if (ssum >= 23'd65536) begin
            mag_q <= 8'd255;
            state_q <= StEmit;
          end else begin
            // Bitwise restoring root: bring down two bits per step.
            logic [17:0] r2;
            logic [17:0] t;
            r2 = {rem_q[15:0], sval[15 - 2*it_q[2:0] -: 2]};
            t  = {7'd0, res_q[8:0], 2'b01};
            if (r2 >= t) begin
              rem_q <= 17'(r2 - t);
              res_q <= {res_q[7:0], 1'b1};
            end else begin
              rem_q <= r2[16:0];
              res_q <= {res_q[7:0], 1'b0};
            end
            it_q <= it_q + 4'd1;
            if (it_q == 4'd8) begin
              mag_q <= res_q[7:0];
              state_q <= StEmit;
            end
          end
        end
        StEmit: begin
          if (!want[slot_q]) begin
            if (slot_q == 2'd2) state_q <= StIdle;
            else slot_q <= slot_q + 2'd1;
          end else if (emit_now) begin
            out_valid_q <= 1'b1;
            out_q.out_column <= (slot_q == 2'd0) ? job_q.col - 11'd1 : job_q.col;
            out_q.out_row <= (slot_q == 2'd2) ? job_q.row : job_q.row - 16'd1;
            out_q.edge_value <= (slot_q == 2'd0) ? mag_q :
                                (slot_q == 2'd1) ? job_q.mid : job_q.gray;
            out_q.last_of_run <= !more_after[slot_q];
            out_q.frame_done <= !more_after[slot_q] && job_q.frame_end;
            if (slot_q == 2'd2) state_q <= StIdle;
            else slot_q <= slot_q + 2'd1;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !pop) |=> out_valid_q)
    else $error("result lost while stalled");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StSqrt) |-> (it_q <= 4'd8))
    else $error("root ran too long");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.frame_done) |-> out_q.last_of_run)
    else $error("frame end not last of run");

endmodule

[rtl/grayscale_sobel_edge_filter.sv]
// Top level of the grayscale Sobel edge filter.
// Input channel: push with pix_i (red, green, blue); an item is taken when push is
// high and full is low. Pixels arrive in raster order.
// Result channel: res_o is valid while empty is low and leaves when pop is high.
// Each pixel yields zero to three results, the last one flagged last_of_run, and the
// final result of a frame flagged frame_done. Window results lag one row and one column.
// Configuration: cfg_we_i writes cfg_data_i to register cfg_idx_i (0 width, 1 height);
// any valid write restarts the frame and clears the window. Write only while idle.
// Path: in the front a pixel passes the stage 1 registers (gray and line store read),
// then the job register. The back end loads the job, then steps through its three
// result slots in StEmit; an interior pixel first passes StSq (squaring) and StSqrt,
// a bitwise square root that stops early when the sum saturates.
// One item is processed at a time in the back end: it takes no new job until the
// last result slot of the previous one is done.
// Reset restores width 640, height 480 and position zero; line stores are not cleared.
// When the receiver stalls, the back end holds its result, the front takes two more
// pixels and then full rises.
module grayscale_sobel_edge_filter #(
  parameter int unsigned MAX_WIDTH = 2048
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push,
  output logic                              full,
  input  gsef_pkg::pix_t                    pix_i,
  output logic                              empty,
  input  logic                              pop,
  output gsef_pkg::res_t                    res_o,
  input  logic                              cfg_we_i,
  input  logic                              cfg_idx_i,
  input  logic [gsef_pkg::CfgDataW-1:0]     cfg_data_i
);
  import gsef_pkg::*;

  logic [WidthRegW-1:0]  width_q;
  logic [HeightRegW-1:0] height_q;
  logic   restart;
  logic   job_valid, job_ready;
  job_t   job;

  assign restart = cfg_we_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 12'd640;
      height_q <= 16'd480;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgWidth:  width_q  <= cfg_data_i[WidthRegW-1:0];
        CfgHeight: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  gsef_front #(.MaxWidth(MAX_WIDTH)) u_front (
    .clk_i, .rst_ni, .restart_i(restart), .width_i(width_q), .height_i(height_q),
    .push_i(push), .pix_i, .full_o(full),
    .job_valid_o(job_valid), .job_o(job), .job_ready_i(job_ready)
  );

  gsef_back u_back (
    .clk_i, .rst_ni, .restart_i(restart),
    .job_valid_i(job_valid), .job_i(job), .job_ready_o(job_ready),
    .empty, .pop, .res_o
  );

endmodule
